>>> src/dctae_pkg.sv
`default_nettype none

package dctae_pkg;

    // Integer bits of a stored row result, sign included; fraction bits come on top.
    localparam int ROW_INT_BITS = 13;

    localparam int ENERGY_W = 22;
    localparam logic [ENERGY_W-1:0] ENERGY_MAX = '1;
    localparam int OUT_W = 18;
    localparam logic [OUT_W-1:0] OUT_MAX = '1;

    // Last count of the pipeline flush after each pass.
    localparam logic [2:0] DRAIN_LAST = 3'd5;

    // Magnitudes with 32 fraction bits: 0..7 hold cos(m*pi/16)/2, 8 holds sqrt(1/8).
    localparam logic [31:0] BASIS_MAG32 [0:8] = '{
        32'd2147483648, 32'd2106220352, 32'd1984016189, 32'd1785567396,
        32'd1518500250, 32'd1193077991, 32'd821806413,  32'd418953276,
        32'd1518500250
    };

    typedef struct packed {
        logic       vld;
        logic       first;
        logic       last;
        logic       row_pass;
        logic [2:0] k;
        logic [2:0] i;
    } dctae_tag_t;

    // Signed DCT basis value C[k][n] with frac fraction bits.
    function automatic logic signed [31:0] basis_coef(input logic [2:0] k,
                                                      input logic [2:0] n,
                                                      input int frac);
        logic [6:0]  prod;
        logic [4:0]  m;
        logic        neg;
        logic [32:0] mag;
        logic [32:0] rnd;
        prod = {4'b0, k} * {3'b0, n, 1'b1};
        m    = prod[4:0];
        neg  = 1'b0;
        if (m > 5'd16) begin
            m = 5'd0 - m;
        end
        if (m > 5'd8) begin
            m   = 5'd16 - m;
            neg = 1'b1;
        end
        if (k == 3'd0) begin
            mag = {1'b0, BASIS_MAG32[8]};
        end else if (m == 5'd8) begin
            mag = '0;
        end else begin
            mag = {1'b0, BASIS_MAG32[m[2:0]]};
        end
        rnd = (mag + (33'd1 << (31 - frac))) >> (32 - frac);
        return neg ? -$signed(rnd[31:0]) : $signed(rnd[31:0]);
    endfunction

endpackage

`default_nettype wire

>>> src/dctae_ram.sv
`default_nettype none

module dctae_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

>>> src/dctae_mac.sv
`default_nettype none

module dctae_mac import dctae_pkg::*; #(
    parameter int COEF_FRAC_BITS   = 14,
    parameter int RESULT_FRAC_BITS = 4
) (
    input  wire logic                                              clk,
    input  wire logic                                              rst_n,
    input  wire dctae_tag_t                                        tag_in,
    input  wire logic signed [RESULT_FRAC_BITS+ROW_INT_BITS-1:0]  sample,
    input  wire logic signed [COEF_FRAC_BITS:0]                    coef,
    output dctae_tag_t                                             res_tag,
    output logic signed      [RESULT_FRAC_BITS+ROW_INT_BITS-1:0]  res_value
);

    localparam int ROW_W   = RESULT_FRAC_BITS + ROW_INT_BITS;
    localparam int COEF_W  = COEF_FRAC_BITS + 1;
    localparam int PROD_W  = ROW_W + COEF_W;
    localparam int ACC_W   = PROD_W + 3;
    localparam int SH_ROW  = COEF_FRAC_BITS - RESULT_FRAC_BITS;
    localparam int SH_COL  = COEF_FRAC_BITS;
    localparam logic [ACC_W-1:0] HALF_ROW = ACC_W'(1) << (SH_ROW - 1);
    localparam logic [ACC_W-1:0] HALF_COL = ACC_W'(1) << (SH_COL - 1);

    dctae_tag_t                tag_c_reg;
    dctae_tag_t                tag_d_reg;
    dctae_tag_t                res_tag_reg;
    dctae_tag_t                res_tag_next;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic signed [ACC_W-1:0]   acc_next;
    logic signed [ROW_W-1:0]   res_reg;
    logic signed [ROW_W-1:0]   res_next;
    logic                      acc_neg;
    logic [ACC_W-1:0]          acc_mag;
    logic [ACC_W-1:0]          rnd_mag;

    always_comb
    begin
        acc_next = tag_c_reg.first ? ACC_W'(prod_reg) : acc_reg + ACC_W'(prod_reg);
    end

    // Round half away from zero on the magnitude, then restore the sign.
    always_comb
    begin
        acc_neg = acc_reg[ACC_W-1];
        acc_mag = acc_neg ? ACC_W'(-acc_reg) : ACC_W'(acc_reg);
        if (tag_d_reg.row_pass)
        begin
            rnd_mag = (acc_mag + HALF_ROW) >> SH_ROW;
        end
        else
        begin
            rnd_mag = (acc_mag + HALF_COL) >> SH_COL;
        end
        res_next = acc_neg ? -$signed(rnd_mag[ROW_W-1:0]) : $signed(rnd_mag[ROW_W-1:0]);
        res_tag_next     = tag_d_reg;
        res_tag_next.vld = tag_d_reg.vld & tag_d_reg.last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_c_reg   <= '0;
            tag_d_reg   <= '0;
            res_tag_reg <= '0;
        end
        else
        begin
            tag_c_reg   <= tag_in;
            tag_d_reg   <= tag_c_reg;
            res_tag_reg <= res_tag_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= sample * coef;
        if (tag_c_reg.vld)
        begin
            acc_reg <= acc_next;
        end
        if (res_tag_next.vld)
        begin
            res_reg <= res_next;
        end
    end

    assign res_tag   = res_tag_reg;
    assign res_value = res_reg;

endmodule

`default_nettype wire

>>> src/dct_block_ac_energy.sv
// AC energy of one 8x8 gray block. Pixels enter in row-major order, one per accepted item;
// after the 64th the block runs an orthonormal 8-point DCT-II over rows, then columns,
// on a single shared multiply-accumulate unit and delivers the sum of |AC| coefficients
// in units of 2^-RESULT_FRAC_BITS. Compute runs two passes of 512 products at one product
// per cycle, each followed by a pipeline flush. in_stall stays high during compute.
// The result sits in an output register, so the next block can be collected while it waits.
`default_nettype none

module dct_block_ac_energy import dctae_pkg::*; #(
    parameter int COEF_FRAC_BITS   = 14,
    parameter int RESULT_FRAC_BITS = 4
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [7:0]        pixel,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic      [OUT_W-1:0]  ac_energy
);

    localparam int ROW_W  = RESULT_FRAC_BITS + ROW_INT_BITS;
    localparam int COEF_W = COEF_FRAC_BITS + 1;

    typedef enum logic [4:0] {
        S_COLLECT   = 5'b00001,
        S_ROW       = 5'b00010,
        S_ROW_DRAIN = 5'b00100,
        S_COL       = 5'b01000,
        S_COL_DRAIN = 5'b10000
    } state_t;

    state_t                    state_reg, state_next;
    logic [5:0]                pix_cnt_reg, pix_cnt_next;
    logic [8:0]                idx_reg, idx_next;
    logic [2:0]                drain_cnt_reg, drain_cnt_next;
    dctae_tag_t                tag_b_reg, tag_b_next;
    logic signed [COEF_W-1:0]  coef_b_reg;
    logic [ENERGY_W-1:0]       energy_reg, energy_next;
    logic                      out_valid_reg, out_valid_next;
    logic [OUT_W-1:0]          ac_energy_reg, ac_energy_next;

    logic                      accept;
    logic                      issue;
    logic                      load_out;
    logic [2:0]                idx_i, idx_k, idx_j;
    logic [7:0]                blk_rd;
    logic [ROW_W-1:0]          row_rd;
    logic signed [ROW_W-1:0]   sample;
    dctae_tag_t                res_tag;
    logic signed [ROW_W-1:0]   res_value;
    logic                      row_we;
    logic [ROW_W-1:0]          res_mag;
    logic [ENERGY_W:0]         energy_sum;
    logic signed [31:0]        coef_full;

    assign idx_i = idx_reg[8:6];
    assign idx_k = idx_reg[5:3];
    assign idx_j = idx_reg[2:0];

    assign in_stall = (state_reg != S_COLLECT);
    assign accept   = in_valid & ~in_stall;
    assign issue    = (state_reg == S_ROW) || (state_reg == S_COL);
    assign load_out = (state_reg == S_COL_DRAIN) && (drain_cnt_reg == DRAIN_LAST)
                      && (!out_valid_reg || !out_stall);

    dctae_ram #(
        .WIDTH (8),
        .DEPTH (64)
    ) u_block_ram (
        .clk   (clk),
        .we    (accept),
        .waddr (pix_cnt_reg),
        .wdata (pixel),
        .raddr ({idx_i, idx_j}),
        .rdata (blk_rd)
    );

    // Row pass writes row r, coefficient k; column pass reads row j, column i.
    assign row_we = res_tag.vld & res_tag.row_pass;

    dctae_ram #(
        .WIDTH (ROW_W),
        .DEPTH (64)
    ) u_row_ram (
        .clk   (clk),
        .we    (row_we),
        .waddr ({res_tag.i, res_tag.k}),
        .wdata (res_value),
        .raddr ({idx_j, idx_i}),
        .rdata (row_rd)
    );

    assign sample = tag_b_reg.row_pass ? $signed({{(ROW_W-8){1'b0}}, blk_rd})
                                       : $signed(row_rd);

    dctae_mac #(
        .COEF_FRAC_BITS   (COEF_FRAC_BITS),
        .RESULT_FRAC_BITS (RESULT_FRAC_BITS)
    ) u_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .tag_in    (tag_b_reg),
        .sample    (sample),
        .coef      (coef_b_reg),
        .res_tag   (res_tag),
        .res_value (res_value)
    );

    assign coef_full = basis_coef(idx_k, idx_j, COEF_FRAC_BITS);

    always_comb
    begin
        tag_b_next.vld      = issue;
        tag_b_next.first    = (idx_j == 3'd0);
        tag_b_next.last     = (idx_j == 3'd7);
        tag_b_next.row_pass = (state_reg == S_ROW);
        tag_b_next.k        = idx_k;
        tag_b_next.i        = idx_i;
    end

    always_comb
    begin
        state_next     = state_reg;
        pix_cnt_next   = pix_cnt_reg;
        idx_next       = idx_reg;
        drain_cnt_next = drain_cnt_reg;
        case (state_reg)
            S_COLLECT:
            begin
                if (accept)
                begin
                    pix_cnt_next = pix_cnt_reg + 6'd1;
                    if (pix_cnt_reg == 6'd63)
                    begin
                        state_next = S_ROW;
                        idx_next   = '0;
                    end
                end
            end
            S_ROW, S_COL:
            begin
                idx_next = idx_reg + 9'd1;
                if (idx_reg == '1)
                begin
                    state_next     = (state_reg == S_ROW) ? S_ROW_DRAIN : S_COL_DRAIN;
                    drain_cnt_next = '0;
                end
            end
            S_ROW_DRAIN:
            begin
                drain_cnt_next = drain_cnt_reg + 3'd1;
                if (drain_cnt_reg == DRAIN_LAST)
                begin
                    state_next = S_COL;
                    idx_next   = '0;
                end
            end
            S_COL_DRAIN:
            begin
                // Hold at the end of the flush until the output register frees up.
                if (drain_cnt_reg != DRAIN_LAST)
                begin
                    drain_cnt_next = drain_cnt_reg + 3'd1;
                end
                if (load_out)
                begin
                    state_next   = S_COLLECT;
                    pix_cnt_next = '0;
                end
            end
            default:
            begin
                state_next = S_COLLECT;
            end
        endcase
    end

    // Accumulate |AC| with saturation; skip the DC term.
    always_comb
    begin
        res_mag     = res_value[ROW_W-1] ? ROW_W'(-res_value) : ROW_W'(res_value);
        energy_sum  = {1'b0, energy_reg} + (ENERGY_W+1)'(res_mag);
        energy_next = energy_reg;
        if (res_tag.vld && !res_tag.row_pass && !(res_tag.k == 3'd0 && res_tag.i == 3'd0))
        begin
            energy_next = (energy_sum > {1'b0, ENERGY_MAX}) ? ENERGY_MAX
                                                            : energy_sum[ENERGY_W-1:0];
        end
        if (load_out)
        begin
            energy_next = '0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg & out_stall;
        ac_energy_next = ac_energy_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
            ac_energy_next = (energy_reg > ENERGY_W'(OUT_MAX)) ? OUT_MAX
                                                               : energy_reg[OUT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_COLLECT;
            pix_cnt_reg   <= '0;
            idx_reg       <= '0;
            drain_cnt_reg <= '0;
            tag_b_reg     <= '0;
            energy_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pix_cnt_reg   <= pix_cnt_next;
            idx_reg       <= idx_next;
            drain_cnt_reg <= drain_cnt_next;
            tag_b_reg     <= tag_b_next;
            energy_reg    <= energy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        coef_b_reg    <= coef_full[COEF_W-1:0];
        ac_energy_reg <= ac_energy_next;
    end

    assign out_valid = out_valid_reg;
    assign ac_energy = ac_energy_reg;

endmodule

`default_nettype wire

>>> src/dctae_checker.sv
`default_nettype none

module dctae_checker import dctae_pkg::*; (
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              in_valid,
    input wire logic              in_stall,
    input wire logic              out_valid,
    input wire logic              out_stall,
    input wire logic [OUT_W-1:0]  ac_energy
);

    logic [5:0] seen_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg <= '0;
        end
        else if (in_valid && !in_stall)
        begin
            seen_reg <= seen_reg + 6'd1;
        end
    end

    // The 64th pixel of a block starts the transform; no item may slip in behind it.
    a_block_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && seen_reg == 6'd63) |=> in_stall)
        else $error("item accepted right after the last pixel of a block");

    // A new result only appears at the end of a compute phase.
    a_result_after_compute: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared while pixels were being collected");

    // A new result only appears once a whole block was collected.
    a_result_on_boundary: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> seen_reg == 6'd0)
        else $error("result appeared mid-block");

    a_energy_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ac_energy <= 18'd261120)
        else $error("AC energy above its bound");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(ac_energy)))
        else $error("stalled result dropped or changed");

endmodule

bind dct_block_ac_energy dctae_checker u_dctae_checker (.*);

`default_nettype wire
